// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ===== sv/ofpcs_pkg.sv =====
package ofpcs_pkg;

	typedef enum logic [1:0] {
		CODEC_UNKNOWN = 2'd0,
		CODEC_VORBIS  = 2'd1,
		CODEC_OPUS    = 2'd2,
		CODEC_FLAC    = 2'd3
	} codec_kind_t;

	localparam int unsigned NUM_SIGS = 4;
	localparam int unsigned SIG_MAX_LEN = 8;

	localparam logic [8:0] POS_MAX = 9'd511;
	localparam logic [9:0] PAGE_HEADER_LEN = 10'd27;
	localparam logic [8:0] SEGCOUNT_OFFSET = 9'd26;
	localparam logic [8:0] MAGIC_LEN = 9'd4;

	localparam logic [7:0] PAGE_MAGIC [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

	localparam logic [7:0] SIG_BYTES [NUM_SIGS][SIG_MAX_LEN] = '{
		'{8'h01, 8'h76, 8'h6F, 8'h72, 8'h62, 8'h69, 8'h73, 8'h00},
		'{8'h4F, 8'h70, 8'h75, 8'h73, 8'h48, 8'h65, 8'h61, 8'h64},
		'{8'h7F, 8'h46, 8'h4C, 8'h41, 8'h43, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h4C, 8'h61, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] SIG_LEN [NUM_SIGS] = '{4'd7, 4'd8, 4'd5, 4'd4};

	localparam codec_kind_t SIG_CODE [NUM_SIGS] = '{
		CODEC_VORBIS, CODEC_OPUS, CODEC_FLAC, CODEC_FLAC
	};

endpackage

// ===== sv/ogg_first_page_codec_sniffer_core.sv =====
// Ogg first page codec sniffer.
// The codec is registered as the last byte advances out of the input register.
// Throughput: one byte per cycle but for the wait below; match state updates per byte.
// A last byte waits in the input register only while the result register holds a beat
// that is not taken in that cycle.
// Reset (arst_n low) clears the byte counter and match state and empties both registers.
module ogg_first_page_codec_sniffer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	input  logic                      last_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output ofpcs_pkg::codec_kind_t    codec_kind
);
	import ofpcs_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        adv;

	logic [8:0]  pos_q;
	logic [7:0]  seg_q;
	logic        magic_q;
	logic [3:0]  alive_q;
	logic        out_valid_q;
	codec_kind_t codec_q;

	logic [9:0]  pos_w;
	logic [9:0]  hdr;
	logic [9:0]  rel;
	logic [9:0]  size;
	logic        in_pkt;
	logic        magic_n;
	logic [7:0]  seg_n;
	logic [3:0]  alive_n;
	codec_kind_t code_n;

	assign adv = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign codec_kind = codec_q;

	always_comb begin
		pos_w = {1'b0, pos_q};
		hdr = PAGE_HEADER_LEN + {2'b00, seg_q};
		rel = pos_w - hdr;
		size = pos_w + 10'd1;
		in_pkt = pos_w >= hdr;

		magic_n = magic_q;
		if (pos_q < MAGIC_LEN && data_s1 != PAGE_MAGIC[pos_q[1:0]]) begin
			magic_n = 1'b0;
		end
		seg_n = (pos_q == SEGCOUNT_OFFSET) ? data_s1 : seg_q;

		alive_n = alive_q;
		for (int k = 0; k < NUM_SIGS; k++) begin
			if (in_pkt && rel < {6'd0, SIG_LEN[k]} && data_s1 != SIG_BYTES[k][rel[2:0]]) begin
				alive_n[k] = 1'b0;
			end
		end

		code_n = CODEC_UNKNOWN;
		if (size >= PAGE_HEADER_LEN && magic_n) begin
			for (int k = NUM_SIGS - 1; k >= 0; k--) begin
				if (alive_n[k] && size >= hdr + {6'd0, SIG_LEN[k]}) begin
					code_n = SIG_CODE[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			seg_q <= '0;
			magic_q <= 1'b1;
			alive_q <= '1;
		end else if (adv) begin
			if (last_s1) begin
				pos_q <= '0;
				seg_q <= '0;
				magic_q <= 1'b1;
				alive_q <= '1;
			end else begin
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 9'd1;
				end
				seg_q <= seg_n;
				magic_q <= magic_n;
				alive_q <= alive_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			codec_q <= code_n;
		end
	end

endmodule

// ===== sv/ofpcs_checker.sv =====
`include "assert_macros.svh"

module ofpcs_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   last_byte,
	input logic                   out_valid,
	input logic                   out_ready,
	input ofpcs_pkg::codec_kind_t codec_kind
);
	import ofpcs_pkg::*;

	// Count of buffers whose last byte is accepted but whose result beat is not yet taken.
	logic [2:0] pending_q;
	logic       in_last;
	logic       out_take;

	assign in_last = in_valid && in_ready && last_byte;
	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_last && !out_take) begin
			pending_q <= pending_q + 3'd1;
		end else if (!in_last && out_take) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(codec_kind))
	`ASSERT_SAME(a_out_has_buffer, clk, arst_n, out_valid, pending_q != 3'd0)
	`ASSERT_SAME(a_pending_bound, clk, arst_n, 1'b1, pending_q <= 3'd2)
	`ASSERT_SAME(a_full_stalls, clk, arst_n, pending_q == 3'd2 && !out_ready, !in_ready)

endmodule

bind ogg_first_page_codec_sniffer_core ofpcs_checker u_ofpcs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.last_byte  (last_byte),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.codec_kind (codec_kind)
);

// ===== dv/ogg_first_page_codec_sniffer_core_tb.sv =====
module ogg_first_page_codec_sniffer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ofpcs_pkg::*;

	typedef enum int {
		ID_VORBIS  = 0,
		ID_OPUS    = 1,
		ID_FLAC    = 2,
		ID_OGGFLAC = 3,
		ID_NONE    = 4
	} id_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} sniff_beat_t;

	localparam logic [31:0] CAPTURE_MAGIC = "OggS";
	localparam int unsigned SEGCNT_AT = 26;
	localparam int unsigned HDR_BYTES = 27;
	localparam logic [8:0] POSITION_CAP = 9'd511;
	localparam logic [63:0] ID_PATTERN [4] = '{
		{8'h01, "vorbis", 8'h00},
		"OpusHead",
		{8'h7F, "FLAC", 24'h000000},
		{"fLaC", 32'h00000000}
	};
	localparam int unsigned ID_LEN [4] = '{7, 8, 5, 4};
	localparam codec_kind_t ID_CODEC [4] = '{CODEC_VORBIS, CODEC_OPUS, CODEC_FLAC, CODEC_FLAC};
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned STALL_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	codec_kind_t codec_kind;

	sniff_beat_t stream_beats[$];
	codec_kind_t codec_expected[$];
	logic [7:0]  page_buf[$];

	logic [8:0]  sniff_pos;
	logic [7:0]  sniff_segs;
	logic        sniff_magic_ok;
	logic [3:0]  sniff_alive;

	int unsigned send_gap = 0;
	logic        send_calm = 1'b0;
	int unsigned recv_hold = 0;
	logic        recv_calm = 1'b0;
	int unsigned results_seen = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatches = 0;

	ogg_first_page_codec_sniffer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.codec_kind(codec_kind)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic clear_sniffer();
		sniff_pos = '0;
		sniff_segs = '0;
		sniff_magic_ok = 1'b1;
		sniff_alive = 4'hF;
	endtask

	task automatic sniff_byte(input logic [7:0] b, input logic last);
		int unsigned pos;
		int unsigned hdr;
		int unsigned rel;
		int unsigned size;
		codec_kind_t code;
		pos = sniff_pos;
		hdr = HDR_BYTES + sniff_segs;
		if (pos < 4 && b != CAPTURE_MAGIC[31 - 8 * pos -: 8]) begin
			sniff_magic_ok = 1'b0;
		end
		if (pos == SEGCNT_AT) begin
			sniff_segs = b;
		end
		if (pos >= HDR_BYTES && pos >= hdr) begin
			rel = pos - hdr;
			for (int k = 0; k < 4; k++) begin
				if (rel < ID_LEN[k] && b != ID_PATTERN[k][63 - 8 * rel -: 8]) begin
					sniff_alive[k] = 1'b0;
				end
			end
		end
		if (last) begin
			size = pos + 1;
			code = CODEC_UNKNOWN;
			if (size >= HDR_BYTES && sniff_magic_ok) begin
				for (int k = 3; k >= 0; k--) begin
					if (sniff_alive[k] && size >= hdr + ID_LEN[k]) begin
						code = ID_CODEC[k];
					end
				end
			end
			codec_expected.insert(codec_expected.size(), code);
			clear_sniffer();
		end else if (sniff_pos < POSITION_CAP) begin
			sniff_pos = sniff_pos + 1'b1;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic int unsigned pick_gap(input logic calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 40);
	endfunction

	task automatic build_page(input int unsigned segs, input id_kind_t kind);
		page_buf.delete();
		for (int i = 0; i < 4; i++) begin
			page_buf.insert(page_buf.size(), CAPTURE_MAGIC[31 - 8 * i -: 8]);
		end
		for (int i = 4; i < SEGCNT_AT; i++) begin
			page_buf.insert(page_buf.size(), 8'($urandom));
		end
		page_buf.insert(page_buf.size(), segs[7:0]);
		for (int i = 0; i < segs; i++) begin
			page_buf.insert(page_buf.size(), 8'($urandom));
		end
		if (kind == ID_NONE) begin
			for (int i = 0; i < 8; i++) begin
				page_buf.insert(page_buf.size(), 8'($urandom));
			end
		end else begin
			for (int i = 0; i < ID_LEN[kind]; i++) begin
				page_buf.insert(page_buf.size(), ID_PATTERN[kind][63 - 8 * i -: 8]);
			end
		end
	endtask

	task automatic flip_bit(input int unsigned idx);
		page_buf[idx] = page_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
	endtask

	task automatic queue_buffer(input int unsigned len);
		sniff_beat_t beat;
		while (page_buf.size() < len) begin
			page_buf.insert(page_buf.size(), 8'($urandom));
		end
		for (int unsigned i = 0; i < len; i++) begin
			beat.data = page_buf[i];
			beat.last = (i == len - 1);
			stream_beats.insert(stream_beats.size(), beat);
		end
	endtask

	always @(posedge clk) begin
		sniff_beat_t next_beat;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				sniff_byte(data_byte, last_byte);
				if ($urandom_range(0, 299) == 0) begin
					send_calm <= !send_calm;
				end
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (stream_beats.size() != 0) begin
					next_beat = stream_beats.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_beat.data;
					last_byte <= next_beat.last;
					send_gap <= pick_gap(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		codec_kind_t want;
		int unsigned gap;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (codec_expected.size() == 0) begin
					report_mismatch($sformatf("codec %0d with no buffer pending", codec_kind));
				end else begin
					want = codec_expected.pop_front();
					if (codec_kind !== want) begin
						report_mismatch($sformatf("codec %0d, expected %s",
							codec_kind, want.name()));
					end
				end
			end
			if ($urandom_range(0, 499) == 0) begin
				recv_calm <= !recv_calm;
			end
			if (out_valid && out_ready && (results_seen == 3 || results_seen == 40)) begin
				recv_hold <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (recv_hold != 0) begin
				recv_hold <= recv_hold - 1;
				out_ready <= 1'b0;
			end else begin
				gap = pick_gap(recv_calm);
				if (gap != 0 && $urandom_range(0, 3) == 0) begin
					recv_hold <= gap - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned segs;
		int unsigned full;
		int unsigned len;
		int unsigned sub;
		id_kind_t kind;

		clear_sniffer();

		build_page(0, ID_VORBIS);
		queue_buffer(page_buf.size());
		build_page(3, ID_OPUS);
		queue_buffer(page_buf.size());
		build_page(1, ID_FLAC);
		queue_buffer(page_buf.size());
		build_page(0, ID_OGGFLAC);
		queue_buffer(page_buf.size() + 2);
		build_page(255, ID_OPUS);
		queue_buffer(page_buf.size());
		build_page(0, ID_VORBIS);
		queue_buffer(page_buf.size() - 1);
		build_page(2, ID_FLAC);
		flip_bit(3);
		queue_buffer(page_buf.size());
		build_page(0, ID_NONE);
		queue_buffer(1);
		build_page(0, ID_OPUS);
		queue_buffer(SEGCNT_AT);
		build_page(0, ID_OPUS);
		queue_buffer(HDR_BYTES);
		build_page(2, ID_OGGFLAC);
		queue_buffer(540);
		build_page(0, ID_NONE);
		queue_buffer(page_buf.size());

		while (stream_beats.size() < 1650) begin
			pick = $urandom_range(0, 99);
			segs = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 255);
			kind = id_kind_t'($urandom_range(0, 4));
			build_page(segs, kind);
			full = page_buf.size();
			if (pick < 62) begin
				if ($urandom_range(0, 3) == 0) begin
					flip_bit($urandom_range(0, full - 1));
				end
				sub = $urandom_range(0, 9);
				if (sub < 6) begin
					len = full + $urandom_range(0, 5);
				end else if (sub < 8) begin
					len = full - $urandom_range(1, 4);
				end else begin
					len = $urandom_range(1, full);
				end
			end else if (pick < 72) begin
				flip_bit($urandom_range(0, 3));
				len = full + $urandom_range(0, 3);
			end else if (pick < 97) begin
				for (int i = ($urandom_range(0, 1) != 0) ? 4 : 0; i < full; i++) begin
					page_buf[i] = 8'($urandom);
				end
				len = $urandom_range(1, 40);
			end else begin
				len = $urandom_range(515, 560);
			end
			queue_buffer(len);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stream_beats.size() != 0 || in_valid) begin
			@(negedge clk);
		end
		while (codec_expected.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
